@@ design/rmbm_pkg.sv @@
// Shared constants, types and helper functions of the region-mapped byte memory.
`timescale 1ns / 1ps

package rmbm_pkg;

    // Region table and store geometry.
    localparam int REGIONS     = 4;
    localparam int NREG_REGS   = 4;
    localparam int STORE_BYTES = 65536;
    localparam int STORE_AW    = $clog2(STORE_BYTES);
    localparam int LANES       = 4;
    localparam int WORDS       = STORE_BYTES / LANES;
    localparam int WORD_AW     = STORE_AW - 2;

    // Register field widths.
    localparam int ADDR_W  = 32;
    localparam int DATA_W  = 32;
    localparam int SIZE_W  = 17;
    localparam int LEN_W   = SIZE_W + 1;
    localparam int PACK_W  = LEN_W + 2;
    localparam int END_W   = (PACK_W + 1 > STORE_AW + 1) ? PACK_W + 1 : STORE_AW + 1;
    localparam int CFG_AW  = 5;
    localparam int LEN_ROUND = 15;

    // Skid queue between classification and execution.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Register kinds: the low bit of the register index.
    localparam logic CFG_KIND_BASE = 1'b0;
    localparam logic CFG_KIND_SIZE = 1'b1;

    // Access kinds.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Access width codes.
    localparam logic [1:0] WIDTH_BYTE = 2'd0;
    localparam logic [1:0] WIDTH_HALF = 2'd1;
    localparam logic [1:0] WIDTH_WORD = 2'd2;
    localparam logic [1:0] WIDTH_BAD  = 2'd3;

    // Region map as seen by the classifier.
    typedef struct packed {
        logic [NREG_REGS-1:0][ADDR_W-1:0] base;
        logic [NREG_REGS-1:0][LEN_W-1:0]  len;
        logic [NREG_REGS-1:0][PACK_W-1:0] offset;
    } rmbm_map_t;

    // One classified access waiting for the back end.
    typedef struct packed {
        logic                op;
        logic                fault;
        logic [STORE_AW-1:0] pos;
        logic [1:0]          wcode;
        logic [DATA_W-1:0]   data;
    } rmbm_entry_t;

    // Number of bytes moved by a width code; zero for the unused code.
    function automatic logic [2:0] nbytes(input logic [1:0] wcode);
        logic [2:0] n;
        case (wcode)
            WIDTH_BYTE: n = 3'd1;
            WIDTH_HALF: n = 3'd2;
            WIDTH_WORD: n = 3'd4;
            default:    n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

@@ design/rmbm_regs.sv @@
// Configuration register file with derived rounded sizes and store offsets.
`timescale 1ns / 1ps

module rmbm_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rmbm_pkg::CFG_AW-1:0]   paddr,
    input  logic [rmbm_pkg::DATA_W-1:0]   pwdata,
    output logic [rmbm_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output rmbm_pkg::rmbm_map_t           map
);
    import rmbm_pkg::*;

    logic [ADDR_W-1:0] base_reg   [NREG_REGS];
    logic [ADDR_W-1:0] base_next  [NREG_REGS];
    logic [SIZE_W-1:0] size_reg   [NREG_REGS];
    logic [SIZE_W-1:0] size_next  [NREG_REGS];
    logic [LEN_W-1:0]  len_reg    [NREG_REGS];
    logic [LEN_W-1:0]  len_next   [NREG_REGS];
    logic [PACK_W-1:0] offset_reg [NREG_REGS];
    logic [PACK_W-1:0] offset_next[NREG_REGS];

    logic       wr_en;
    logic [1:0] reg_sel;
    logic       reg_kind;

    assign pready   = 1'b1;
    assign wr_en    = psel & penable & pwrite;
    assign reg_sel  = paddr[CFG_AW-1:3];
    assign reg_kind = paddr[2];

    // Register writes, with rounded sizes and packed offsets following the new values.
    always_comb
    begin
        logic [PACK_W-1:0] acc;
        acc = '0;
        for (int r = 0; r < NREG_REGS; r++)
        begin
            base_next[r] = base_reg[r];
            size_next[r] = size_reg[r];
            if (wr_en && (reg_sel == 2'(r)))
            begin
                if (reg_kind == CFG_KIND_SIZE)
                    size_next[r] = pwdata[SIZE_W-1:0];
                else
                    base_next[r] = pwdata;
            end
            len_next[r] = (LEN_W'(size_next[r]) + LEN_W'(LEN_ROUND)) & ~LEN_W'(LEN_ROUND);
            offset_next[r] = acc;
            acc = acc + PACK_W'(len_next[r]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NREG_REGS; r++)
            begin
                base_reg[r]   <= '0;
                size_reg[r]   <= '0;
                len_reg[r]    <= '0;
                offset_reg[r] <= '0;
            end
        end
        else
        begin
            for (int r = 0; r < NREG_REGS; r++)
            begin
                base_reg[r]   <= base_next[r];
                size_reg[r]   <= size_next[r];
                len_reg[r]    <= len_next[r];
                offset_reg[r] <= offset_next[r];
            end
        end
    end

    // Read-back mux.
    always_comb
    begin
        case (reg_kind)
            CFG_KIND_BASE: prdata = base_reg[reg_sel];
            CFG_KIND_SIZE: prdata = {(DATA_W - SIZE_W)'(0), size_reg[reg_sel]};
            default:       prdata = '0;
        endcase
    end

    // Map handed to the classifier.
    always_comb
    begin
        for (int r = 0; r < NREG_REGS; r++)
        begin
            map.base[r]   = base_reg[r];
            map.len[r]    = len_reg[r];
            map.offset[r] = offset_reg[r];
        end
    end

endmodule

@@ design/rmbm_front.sv @@
// Front end: takes accesses, matches them against the regions and classifies them.
`timescale 1ns / 1ps

module rmbm_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          op,
    input  logic [rmbm_pkg::ADDR_W-1:0]   address,
    input  logic [1:0]                    access_width,
    input  logic [rmbm_pkg::DATA_W-1:0]   write_data,
    input  logic                          clearing,
    input  rmbm_pkg::rmbm_map_t           map,
    input  logic                          q_full,
    output logic                          q_push,
    output rmbm_pkg::rmbm_entry_t         q_data
);
    import rmbm_pkg::*;

    // Stage A holds the accepted access.
    logic              a_valid_reg;
    logic              a_op_reg;
    logic [ADDR_W-1:0] a_addr_reg;
    logic [1:0]        a_wcode_reg;
    logic [DATA_W-1:0] a_data_reg;

    // Stage B holds the per-region hit results.
    logic               b_valid_reg;
    logic               b_op_reg;
    logic [1:0]         b_wcode_reg;
    logic [DATA_W-1:0]  b_data_reg;
    logic [REGIONS-1:0] b_hit_reg;
    logic [LEN_W-1:0]   b_rel_reg [REGIONS];

    logic               a_hit [REGIONS];
    logic [LEN_W-1:0]   a_rel [REGIONS];

    logic accept;
    logic a_move;
    logic b_move;
    logic b_ready;

    assign b_move  = b_valid_reg & ~q_full;
    assign b_ready = ~b_valid_reg | b_move;
    assign a_move  = a_valid_reg & b_ready;
    assign busy    = clearing | (a_valid_reg & ~a_move);
    assign accept  = start & ~busy;

    // Region hit test: base <= address < base + rounded size, without wraparound.
    always_comb
    begin
        logic [ADDR_W:0] diff;
        for (int r = 0; r < REGIONS; r++)
        begin
            diff = {1'b0, a_addr_reg} - {1'b0, map.base[r]};
            a_hit[r] = (map.len[r] != '0) && !diff[ADDR_W]
                       && (diff[ADDR_W-1:0] < ADDR_W'(map.len[r]));
            a_rel[r] = diff[LEN_W-1:0];
        end
    end

    // Pipeline control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                a_valid_reg <= 1'b1;
            else if (a_move)
                a_valid_reg <= 1'b0;
            if (a_move)
                b_valid_reg <= 1'b1;
            else if (b_move)
                b_valid_reg <= 1'b0;
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_op_reg    <= op;
            a_addr_reg  <= address;
            a_wcode_reg <= access_width;
            a_data_reg  <= write_data;
        end
        if (a_move)
        begin
            b_op_reg    <= a_op_reg;
            b_wcode_reg <= a_wcode_reg;
            b_data_reg  <= a_data_reg;
            for (int r = 0; r < REGIONS; r++)
            begin
                b_hit_reg[r] <= a_hit[r];
                b_rel_reg[r] <= a_rel[r];
            end
        end
    end

    // Pick the lowest-numbered hit and check that the whole access fits its region and the store.
    always_comb
    begin
        logic [2:0]          nb;
        logic                found;
        logic                ok;
        logic [STORE_AW-1:0] pos;
        logic                fits;
        logic [END_W-1:0]    spos;
        logic                in_store;
        nb    = nbytes(b_wcode_reg);
        found = 1'b0;
        ok    = 1'b0;
        pos   = '0;
        for (int r = 0; r < REGIONS; r++)
        begin
            fits     = ({1'b0, b_rel_reg[r]} + (LEN_W + 1)'(nb)) <= {1'b0, map.len[r]};
            spos     = END_W'(map.offset[r]) + END_W'(b_rel_reg[r]);
            in_store = (spos + END_W'(nb)) <= END_W'(STORE_BYTES);
            if (!found && b_hit_reg[r])
            begin
                found = 1'b1;
                ok    = fits & in_store;
                pos   = spos[STORE_AW-1:0];
            end
        end
        q_data.op    = b_op_reg;
        q_data.fault = (b_wcode_reg == WIDTH_BAD) || !ok;
        q_data.pos   = pos;
        q_data.wcode = b_wcode_reg;
        q_data.data  = b_data_reg;
    end

    assign q_push = b_move;

endmodule

@@ design/rmbm_queue.sv @@
// Short queue of classified accesses between the front end and the back end.
`timescale 1ns / 1ps

module rmbm_queue
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  rmbm_pkg::rmbm_entry_t   push_data,
    input  logic                    pop,
    output rmbm_pkg::rmbm_entry_t   head,
    output logic                    empty,
    output logic                    full
);
    import rmbm_pkg::*;

    rmbm_entry_t         entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign head  = entry_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

@@ design/rmbm_back.sv @@
// Back end: byte-lane store, clearing pass after reset and result formatting.
`timescale 1ns / 1ps

module rmbm_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  rmbm_pkg::rmbm_entry_t         q_head,
    output logic                          q_pop,
    output logic                          clearing,
    output logic                          done,
    output logic [rmbm_pkg::DATA_W-1:0]   read_data,
    output logic                          fault
);
    import rmbm_pkg::*;

    logic               clear_active_reg;
    logic [WORD_AW-1:0] clear_cnt_reg;

    // Issue stage to result stage.
    logic              s1_valid_reg;
    logic              s1_op_reg;
    logic              s1_fault_reg;
    logic [1:0]        s1_off_reg;
    logic [1:0]        s1_wcode_reg;

    logic              done_reg;
    logic [DATA_W-1:0] read_data_reg;
    logic [DATA_W-1:0] read_data_next;
    logic              fault_reg;

    logic [7:0]        lane_rd [LANES];
    logic [1:0]        off;
    logic [WORD_AW-1:0] word;
    logic [2:0]        nb;

    assign clearing = clear_active_reg;
    assign q_pop    = ~q_empty & ~clear_active_reg;
    assign off      = q_head.pos[1:0];
    assign word     = q_head.pos[STORE_AW-1:2];
    assign nb       = nbytes(q_head.wcode);

    // One memory per byte lane; an unaligned access uses the next word in the low lanes.
    for (genvar L = 0; L < LANES; L++)
    begin : g_lane
        logic [7:0]         mem [WORDS];
        logic [7:0]         rd_reg;
        logic [1:0]         k;
        logic               active;
        logic               wen;
        logic [WORD_AW-1:0] lane_word;
        logic [7:0]         wbyte;

        assign k         = 2'(L) - off;
        assign active    = {1'b0, k} < nb;
        assign lane_word = (2'(L) < off) ? word + 1'b1 : word;
        assign wen       = q_pop & (q_head.op == OP_WRITE) & ~q_head.fault & active;
        assign wbyte     = 8'(q_head.data >> {k, 3'b000});
        assign lane_rd[L] = rd_reg;

        always_ff @(posedge clk)
        begin
            if (clear_active_reg)
                mem[clear_cnt_reg] <= 8'h00;
            else if (wen)
                mem[lane_word] <= wbyte;
            rd_reg <= mem[lane_word];
        end
    end

    // Clearing pass over every word after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clear_cnt_reg    <= '0;
        end
        else if (clear_active_reg)
        begin
            if (clear_cnt_reg == WORD_AW'(WORDS - 1))
                clear_active_reg <= 1'b0;
            clear_cnt_reg <= clear_cnt_reg + 1'b1;
        end
    end

    // Control of the issue and result stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= q_pop;
            done_reg     <= s1_valid_reg;
        end
    end

    // Payload of the issue and result stages.
    always_ff @(posedge clk)
    begin
        s1_op_reg     <= q_head.op;
        s1_fault_reg  <= q_head.fault;
        s1_off_reg    <= off;
        s1_wcode_reg  <= q_head.wcode;
        read_data_reg <= read_data_next;
        fault_reg     <= s1_fault_reg;
    end

    // Gather the lanes back into little-endian order; zero for writes and faults.
    always_comb
    begin
        logic [2:0] s1_nb;
        logic [1:0] lane;
        s1_nb = nbytes(s1_wcode_reg);
        read_data_next = '0;
        for (int k = 0; k < LANES; k++)
        begin
            lane = 2'(k) + s1_off_reg;
            if ((3'(k) < s1_nb) && (s1_op_reg == OP_READ) && !s1_fault_reg)
                read_data_next[8*k +: 8] = lane_rd[lane];
        end
    end

    assign done      = done_reg;
    assign read_data = read_data_reg;
    assign fault     = fault_reg;

endmodule

@@ design/region_mapped_byte_memory.sv @@
// Top level of the region-mapped byte memory.
//
//   Channel   Handshake                         Payload
//   access    start in, busy out                op, address, access_width, write_data
//   result    done out (one-cycle strobe)       read_data, fault
//   config    psel, penable, pwrite, pready     paddr, pwdata, prdata
//
// One access is taken per cycle when the front end is not held; the result strobe
// follows the accepting edge through two front stages, the queue, the lane memory
// read and the result register.
// After reset a clearing pass zeroes the store, one word of all four byte lanes per
// cycle, over all 16384 words; busy stays high during it.
// The receiver cannot stall: each result transfer is shown for exactly one cycle.
// busy rises only while the front end waits on a full queue or during the clearing pass.
`timescale 1ns / 1ps

module region_mapped_byte_memory
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          op,
    input  logic [rmbm_pkg::ADDR_W-1:0]   address,
    input  logic [1:0]                    access_width,
    input  logic [rmbm_pkg::DATA_W-1:0]   write_data,
    output logic                          done,
    output logic [rmbm_pkg::DATA_W-1:0]   read_data,
    output logic                          fault,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rmbm_pkg::CFG_AW-1:0]   paddr,
    input  logic [rmbm_pkg::DATA_W-1:0]   pwdata,
    output logic [rmbm_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import rmbm_pkg::*;

    rmbm_map_t   map;
    rmbm_entry_t q_data;
    rmbm_entry_t q_head;
    logic        q_push;
    logic        q_pop;
    logic        q_empty;
    logic        q_full;
    logic        clearing;

    // Region registers.
    rmbm_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .map     (map)
    );

    // Classification.
    rmbm_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .address      (address),
        .access_width (access_width),
        .write_data   (write_data),
        .clearing     (clearing),
        .map          (map),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_data)
    );

    // Decoupling queue.
    rmbm_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    // Store access and results.
    rmbm_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .done      (done),
        .read_data (read_data),
        .fault     (fault)
    );

endmodule
